// ===== src/four_stop_gradient_map_rgb565_core_defines.svh =====
// Assertion macros used by the checker file
`ifndef FOUR_STOP_GRADIENT_MAP_RGB565_CORE_DEFINES_SVH
`define FOUR_STOP_GRADIENT_MAP_RGB565_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FSGM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FSGM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fsgm_pkg.sv =====
`default_nettype none
package fsgm_pkg;

	// Register map
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned STOP_W = 24;
	localparam int unsigned CH_W   = 8;

	typedef enum logic [1:0] {
		REG_STOP_BLACK     = 2'd0,
		REG_STOP_SHADOW    = 2'd1,
		REG_STOP_HIGHLIGHT = 2'd2,
		REG_STOP_WHITE     = 2'd3
	} fsgm_reg_t;

	localparam logic [STOP_W-1:0] RST_STOP_BLACK     = 24'h000000;
	localparam logic [STOP_W-1:0] RST_STOP_SHADOW    = 24'h555555;
	localparam logic [STOP_W-1:0] RST_STOP_HIGHLIGHT = 24'hAAAAAA;
	localparam logic [STOP_W-1:0] RST_STOP_WHITE     = 24'hFFFFFF;

	// Segment boundaries on the luminance axis
	localparam logic [7:0] LUM_SEG1 = 8'd85;
	localparam logic [7:0] LUM_SEG2 = 8'd170;

	// floor(x / 85) = (x * RECIP_85) >> RECIP_SHIFT for x below 39568
	localparam logic [14:0] RECIP_85    = 15'd24673;
	localparam int unsigned RECIP_SHIFT = 21;

	typedef logic [3:0][STOP_W-1:0] fsgm_stops_t;

	// One channel after segment selection: start value, step magnitude and step sign
	typedef struct packed {
		logic [CH_W-1:0] base;
		logic [CH_W-1:0] mag;
		logic            neg;
	} fsgm_chan_t;

	// Per-stage load strobes from the pipeline control
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} fsgm_adv_t;

endpackage
`default_nettype wire

// ===== src/fsgm_seg.sv =====
`default_nettype none
module fsgm_seg (
	input  wire logic                           clk,
	input  wire logic                           en_s1,
	input  wire logic [7:0]                     luminance,
	input  wire fsgm_pkg::fsgm_stops_t          stops,
	output fsgm_pkg::fsgm_chan_t [2:0]          chan_s1,
	output logic [6:0]                          t_s1
);

	logic [1:0]                       seg;
	logic [1:0]                       seg_up;
	logic [7:0]                       base_lum;
	logic [fsgm_pkg::STOP_W-1:0]      stop_a;
	logic [fsgm_pkg::STOP_W-1:0]      stop_b;
	fsgm_pkg::fsgm_chan_t [2:0]       chan;

	// Pick the segment and the offset inside it
	always_comb begin
		if (luminance >= fsgm_pkg::LUM_SEG2) begin
			seg      = 2'd2;
			base_lum = fsgm_pkg::LUM_SEG2;
		end else if (luminance >= fsgm_pkg::LUM_SEG1) begin
			seg      = 2'd1;
			base_lum = fsgm_pkg::LUM_SEG1;
		end else begin
			seg      = 2'd0;
			base_lum = 8'd0;
		end
		seg_up = seg + 2'd1;
		stop_a = stops[seg];
		stop_b = stops[seg_up];
	end

	// Split into channels, keep the step as sign and magnitude
	always_comb begin
		logic [8:0] diff;
		logic [8:0] diff_abs;
		for (int c = 0; c < 3; c++) begin
			diff = {1'b0, stop_b[c*8 +: 8]} - {1'b0, stop_a[c*8 +: 8]};
			diff_abs = diff[8] ? (9'd0 - diff) : diff;
			chan[c].base = stop_a[c*8 +: 8];
			chan[c].mag  = diff_abs[7:0];
			chan[c].neg  = diff[8];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			chan_s1 <= chan;
			t_s1    <= 7'(luminance - base_lum);
		end
	end

endmodule
`default_nettype wire

// ===== src/fsgm_lane.sv =====
`default_nettype none
module fsgm_lane (
	input  wire logic                 clk,
	input  wire fsgm_pkg::fsgm_adv_t  adv,
	input  wire logic                 green,
	input  wire fsgm_pkg::fsgm_chan_t chan_s1,
	input  wire logic [6:0]           t_s1,
	output logic [5:0]                qnt_s4
);

	logic [14:0] prod_s2;
	logic        neg_s2;
	logic [7:0]  base_s2;
	logic [7:0]  quot_s3;
	logic        neg_s3;
	logic [7:0]  base_s3;
	logic [29:0] recip_full;
	logic [7:0]  chan_val;
	logic [14:0] num;
	logic [14:0] fold;

	// Stage 2: step magnitude times offset
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= 15'(chan_s1.mag * t_s1);
			neg_s2  <= chan_s1.neg;
			base_s2 <= chan_s1.base;
		end
	end

	// Stage 3: divide by 85 through the reciprocal
	assign recip_full = 30'(prod_s2) * 30'(fsgm_pkg::RECIP_85);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			quot_s3 <= recip_full[fsgm_pkg::RECIP_SHIFT +: 8];
			neg_s3  <= neg_s2;
			base_s3 <= base_s2;
		end
	end

	// Stage 4: apply the signed step, then round to 5 or 6 bits
	always_comb begin
		chan_val = neg_s3 ? (base_s3 - quot_s3) : (base_s3 + quot_s3);
		if (green) begin
			num = ({chan_val, 6'b0} - 15'(chan_val)) + 15'd127;
		end else begin
			num = ({1'b0, chan_val, 5'b0} - 15'(chan_val)) + 15'd127;
		end
		// floor(num / 255) for num below 32640
		fold = num + 15'd1 + 15'(num[14:8]);
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			qnt_s4 <= fold[13:8];
		end
	end

endmodule
`default_nettype wire

// ===== src/four_stop_gradient_map_rgb565_core.sv =====
`default_nettype none
// Recolors a stream of 8-bit luminance words to RGB565 through a four-stop
// ramp whose stops (0xRRGGBB) sit at luminance 0, 85, 170 and 255 and are
// set over the APB port at byte addresses 0x0, 0x4, 0x8 and 0xC. One word is
// taken every cycle while s_tready is high; each result passes in turn through
// the four register stages (segment select, step multiply, divide by
// 85 through a reciprocal multiply, add and 5/6/5 rounding). When m_tready
// drops, the stages fill and s_tready falls only once all four hold data.
// Stop registers are to be written only while no word is in flight.
module four_stop_gradient_map_rgb565_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// APB configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fsgm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// Input stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,  // [7:0] luminance
	// Output stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [15:0]                      m_tdata   // [15:0] rgb565
);

	fsgm_pkg::fsgm_stops_t      stops_q;
	fsgm_pkg::fsgm_reg_t        reg_sel;
	fsgm_pkg::fsgm_chan_t [2:0] chan_s1;
	fsgm_pkg::fsgm_adv_t        adv;
	logic [6:0]                 t_s1;
	logic [2:0][5:0]            qnt_s4;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic                       valid_s4;
	logic                       rdy_s1;
	logic                       rdy_s2;
	logic                       rdy_s3;
	logic                       rdy_s4;

	// Stop registers
	assign pready  = 1'b1;
	assign reg_sel = fsgm_pkg::fsgm_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stops_q[fsgm_pkg::REG_STOP_BLACK]     <= fsgm_pkg::RST_STOP_BLACK;
			stops_q[fsgm_pkg::REG_STOP_SHADOW]    <= fsgm_pkg::RST_STOP_SHADOW;
			stops_q[fsgm_pkg::REG_STOP_HIGHLIGHT] <= fsgm_pkg::RST_STOP_HIGHLIGHT;
			stops_q[fsgm_pkg::REG_STOP_WHITE]     <= fsgm_pkg::RST_STOP_WHITE;
		end else if (psel && penable && pwrite && pready) begin
			stops_q[reg_sel] <= pwdata[fsgm_pkg::STOP_W-1:0];
		end
	end

	assign prdata = {8'd0, stops_q[reg_sel]};

	// Pipeline control: a stage loads when it is empty or drains this cycle
	assign rdy_s4   = !valid_s4 || m_tready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign adv.s2   = rdy_s2;
	assign adv.s3   = rdy_s3;
	assign adv.s4   = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= s_tvalid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: segment select
	fsgm_seg u_seg (
		.clk       (clk),
		.en_s1     (rdy_s1),
		.luminance (s_tdata),
		.stops     (stops_q),
		.chan_s1   (chan_s1),
		.t_s1      (t_s1)
	);

	// Stages 2 to 4, one lane per channel (2 red, 1 green, 0 blue)
	for (genvar c = 0; c < 3; c++) begin : g_lane
		fsgm_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.green   (c == 1),
			.chan_s1 (chan_s1[c]),
			.t_s1    (t_s1),
			.qnt_s4  (qnt_s4[c])
		);
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {qnt_s4[2][4:0], qnt_s4[1], qnt_s4[0][4:0]};

endmodule
`default_nettype wire

// ===== src/fsgm_check.sv =====
`default_nettype none
`include "four_stop_gradient_map_rgb565_core_defines.svh"
module fsgm_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// A stalled output word holds
	`FSGM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed under stall")

	// Output valid drops only after a handshake
	`FSGM_ASSERT_IMP(a_out_drop, $fell(m_tvalid), $past(m_tready), "output word lost")

	// Input stalls only when the output holds a word and is blocked
	`FSGM_ASSERT_IMP(a_in_stall, !s_tready, m_tvalid && !m_tready, "input stalled with room in pipeline")

	// With m_tready held high after it is taken, an input word reaches the output valid
	`FSGM_ASSERT_NXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid, "result missing after pipeline latency")

endmodule

bind four_stop_gradient_map_rgb565_core fsgm_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
